// File: rtl/rco_pkg.sv
// ----------------------------------------------------------------------------
// rco_pkg : shared types and constants for the rod-cutting optimiser
// Field widths of the stream beats and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rco_pkg;

  // input beat fields
  localparam int unsigned PRICE_W   = 16;
  localparam int unsigned IN_DATA_W = 16;

  // output beat fields
  localparam int unsigned PIECE_LEN_W = 7;
  localparam int unsigned PIECE_PRC_W = 16;
  localparam int unsigned TOTAL_W     = 22;
  localparam int unsigned OUT_DATA_W  = 48;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // take one price beat
    logic init_rd;   // read the uncut price for the current length
    logic cut_rd;    // read one cut candidate and step the cut
    logic wr_best;   // store best value and first cut of the current length
    logic emit_rd;   // resolve the next piece and read its price
    logic out_load;  // move a piece into the output register
  } rco_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cut_end;   // every cut of the current length issued
    logic len_last;  // current length is the rod length
    logic rem_zero;  // nothing left of the rod to emit
    logic out_free;  // output register can take a beat
  } rco_status_t;

endpackage

// File: rtl/rco_ctrl.sv
// ----------------------------------------------------------------------------
// rco_ctrl : sequencing controller for the rod-cutting optimiser
// Loads the price list, steps the bottom-up recurrence over lengths and
// cuts, then walks the first-cut table to emit the pieces.
// ----------------------------------------------------------------------------
module rco_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tlast,
  input  rco_pkg::rco_status_t status,
  output rco_pkg::rco_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_CUT,
    S_WR,
    S_ERF,
    S_ERP,
    S_EOUT
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_rd = 1'b1;
        state_nxt   = S_CUT;
      end
      S_CUT: begin
        if (status.cut_end) state_nxt = S_WR;
        else cmd.cut_rd = 1'b1;
      end
      S_WR: begin
        cmd.wr_best = 1'b1;
        state_nxt   = status.len_last ? S_ERF : S_INIT;
      end
      S_ERF: begin
        // first-cut entry for the remaining length is read this cycle
        state_nxt = S_ERP;
      end
      S_ERP: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EOUT;
      end
      S_EOUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.rem_zero ? S_LOAD : S_ERF;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rco_datapath.sv
// ----------------------------------------------------------------------------
// rco_datapath : stores, counters and compare unit of the rod-cutting optimiser
// Price, best-value and first-cut memories with registered reads, one
// add and compare per cycle, and the output beat register.
// ----------------------------------------------------------------------------
module rco_datapath #(
  parameter int unsigned MAX_LENGTH = 64,
  parameter int unsigned PRICE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rco_pkg::rco_cmd_t                   cmd,
  input  logic [rco_pkg::PRICE_W-1:0]         in_price,
  input  logic                                in_last,
  output rco_pkg::rco_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rco_pkg::PIECE_LEN_W-1:0]     out_piece_length,
  output logic [rco_pkg::PIECE_PRC_W-1:0]     out_piece_price,
  output logic [rco_pkg::TOTAL_W-1:0]         out_total_value,
  output logic                                out_final_piece
);

  localparam int unsigned PW = (PRICE_BITS < rco_pkg::PRICE_W) ? PRICE_BITS
                                                               : rco_pkg::PRICE_W;
  localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned VW = PW + $clog2(MAX_LENGTH);

  // stores
  logic [PW-1:0] price_mem [0:MAX_LENGTH-1];
  logic [VW-1:0] best_mem  [0:MAX_LENGTH-1];
  logic [LW-1:0] first_mem [0:MAX_LENGTH-1];

  logic [PW-1:0] p_q;
  logic [VW-1:0] b_q;
  logic [LW-1:0] f_q;

  // counters and working registers
  logic [LW-1:0] cnt_r, n_r, len_r, cut_r, rem_r, piece_r, first_r;
  logic [VW-1:0] best_r, total_r;
  logic          q_init_r, q_cut_r;
  logic [LW-1:0] q_cutv_r;

  // output register
  logic                         out_valid_r;
  logic [LW-1:0]                out_len_r;
  logic [PW-1:0]                out_price_r;
  logic [VW-1:0]                out_total_r;
  logic                         out_final_r;

  logic          cnt_room;
  logic [LW-1:0] cnt_inc;
  logic [LW-1:0] len_m1, cut_m1, len_cut_m1, rem_m1, piece, piece_m1, piece_r_m1;
  logic [AW-1:0] p_raddr;
  logic [VW-1:0] cand;

  assign cnt_room   = (cnt_r < LW'(MAX_LENGTH));
  assign cnt_inc    = cnt_room ? (cnt_r + 1'b1) : cnt_r;
  assign len_m1     = len_r - 1'b1;
  assign cut_m1     = cut_r - 1'b1;
  assign len_cut_m1 = len_r - cut_r - 1'b1;
  assign rem_m1     = rem_r - 1'b1;
  assign piece_r_m1 = piece_r - 1'b1;
  assign cand       = VW'(p_q) + b_q;

  // piece from the first-cut table, falling back to the whole remainder
  always_comb begin
    piece = f_q;
    if (f_q == '0 || f_q > rem_r) piece = rem_r;
  end
  assign piece_m1 = piece - 1'b1;

  // price read address, held on the current piece while its beat waits
  always_comb begin
    if (cmd.init_rd)      p_raddr = len_m1[AW-1:0];
    else if (cmd.emit_rd) p_raddr = piece_m1[AW-1:0];
    else if (cmd.cut_rd)  p_raddr = cut_m1[AW-1:0];
    else                  p_raddr = piece_r_m1[AW-1:0];
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && cnt_room) price_mem[cnt_r[AW-1:0]] <= in_price[PW-1:0];
    if (cmd.wr_best) begin
      best_mem[len_m1[AW-1:0]]  <= best_r;
      first_mem[len_m1[AW-1:0]] <= first_r;
    end
    p_q <= price_mem[p_raddr];
    b_q <= best_mem[len_cut_m1[AW-1:0]];
    f_q <= first_mem[rem_m1[AW-1:0]];
  end

  // list loading, length and cut stepping, emission walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      q_init_r <= 1'b0;
      q_cut_r  <= 1'b0;
    end else begin
      q_init_r <= cmd.init_rd;
      q_cut_r  <= cmd.cut_rd;
      q_cutv_r <= cut_r;
      if (cmd.load) begin
        if (in_last) begin
          cnt_r <= '0;
          n_r   <= cnt_inc;
          len_r <= LW'(1);
        end else begin
          cnt_r <= cnt_inc;
        end
      end
      if (cmd.init_rd) cut_r <= LW'(1);
      if (cmd.cut_rd)  cut_r <= cut_r + 1'b1;
      if (cmd.wr_best) begin
        total_r <= best_r;
        len_r   <= len_r + 1'b1;
        rem_r   <= n_r;
      end
      if (cmd.emit_rd) begin
        piece_r <= piece;
        rem_r   <= rem_r - piece;
      end
    end
  end

  // compare unit: uncut price first, then strictly better cuts only
  always_ff @(posedge clk) begin
    if (q_init_r) begin
      best_r  <= VW'(p_q);
      first_r <= len_r;
    end else if (q_cut_r && cand > best_r) begin
      best_r  <= cand;
      first_r <= q_cutv_r;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        out_len_r   <= piece_r;
        out_price_r <= p_q;
        out_total_r <= total_r;
        out_final_r <= (rem_r == '0);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_piece_length = rco_pkg::PIECE_LEN_W'(out_len_r);
  assign out_piece_price  = rco_pkg::PIECE_PRC_W'(out_price_r);
  assign out_total_value  = rco_pkg::TOTAL_W'(out_total_r);
  assign out_final_piece  = out_final_r;

  // status
  assign status.cut_end  = (cut_r == len_r);
  assign status.len_last = (len_r == n_r);
  assign status.rem_zero = (rem_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// File: rtl/rod_cutting_optimizer_core.sv
// Prices load at one beat per cycle; after the beat marked last the solve steps
// every length (uncut price read, one add and compare per cut, cut check, store).
// Emission: each piece is a first-cut lookup, then a price lookup, then a wait for a free output register.
// A new list is taken only after the last piece of the previous list is in the output register.
// Reset (synchronous, rst_n low) clears the load count, sequencer and output valid;
// the stores are not cleared and are always written before their read data is used.
// ----------------------------------------------------------------------------
// rod_cutting_optimizer_core : rod-cutting optimiser top level
// Takes a price list as a stream, solves the bottom-up recurrence and
// streams out the optimal pieces in cut order.
// ----------------------------------------------------------------------------
module rod_cutting_optimizer_core #(
  parameter int unsigned MAX_LENGTH = 64,
  parameter int unsigned PRICE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rco_pkg::IN_DATA_W-1:0]   in_tdata,   // [15:0] price
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rco_pkg::OUT_DATA_W-1:0]  out_tdata,  // [6:0] piece_length,
                                                      // [22:7] piece_price,
                                                      // [44:23] total_value
  output logic                            out_tlast
);

  rco_pkg::rco_cmd_t    cmd;
  rco_pkg::rco_status_t status;

  logic [rco_pkg::PIECE_LEN_W-1:0] piece_length;
  logic [rco_pkg::PIECE_PRC_W-1:0] piece_price;
  logic [rco_pkg::TOTAL_W-1:0]     total_value;

  // sequencer
  rco_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .status    (status),
    .cmd       (cmd)
  );

  // stores and compare unit
  rco_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_price         (in_tdata[rco_pkg::PRICE_W-1:0]),
    .in_last          (in_tlast),
    .status           (status),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_piece_length (piece_length),
    .out_piece_price  (piece_price),
    .out_total_value  (total_value),
    .out_final_piece  (out_tlast)
  );

  // pack the output beat, zero padded to whole bytes
  assign out_tdata = {3'b000, total_value, piece_price, piece_length};

endmodule

// File: sim/tb_rod_cutting_optimizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rod_cutting_optimizer_core : self-checking bench for the rod-cutting core
// Streams price lists into the core and recomputes the optimal cut plan of
// every closed list. Each piece beat is checked against that plan, under
// random gaps on both sides, a long output stall and a list beyond the store.
// ----------------------------------------------------------------------------
module tb_rod_cutting_optimizer_core;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned N_ITEMS = 220;
  localparam int unsigned N_DIR   = 22;

  typedef enum int {
    PR_RANDOM, PR_LINEAR, PR_CONVEX, PR_MULTIPLE, PR_SPARSE, PR_FLAT_MAX
  } price_style_t;

  typedef struct {
    logic [rco_pkg::PRICE_W-1:0] price;
    logic                        last;
  } price_beat_t;

  typedef struct packed {
    logic [rco_pkg::PIECE_LEN_W-1:0] len;
    logic [rco_pkg::PIECE_PRC_W-1:0] price;
    logic [rco_pkg::TOTAL_W-1:0]     total;
    logic                            fin;
  } piece_t;

  // hand-picked lists: single extremes, a textbook table, ties and zero prices
  localparam logic [15:0] DIR_PRICES [N_DIR] = '{
    16'hFFFF, 16'h0000, 16'd1, 16'd5, 16'd8, 16'd9, 16'd2, 16'd4, 16'd6,
    16'd3, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd5, 16'd8, 16'd9, 16'd10,
    16'd17, 16'd17, 16'd20
  };
  localparam bit DIR_LAST [N_DIR] = '{
    1, 1, 0, 0, 0, 1, 0, 0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [rco_pkg::IN_DATA_W-1:0]   in_tdata = '0;   // [15:0] price
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [rco_pkg::OUT_DATA_W-1:0]  out_tdata;       // [6:0] piece_length,
                                                    // [22:7] piece_price,
                                                    // [44:23] total_value
  logic                            out_tlast;

  // stimulus and expectation stores
  price_beat_t price_beats[$];
  piece_t      pieces_due[$];

  // predictor state
  logic [rco_pkg::PRICE_W-1:0] held_prices [MAX_LEN];
  int unsigned                 best_value  [MAX_LEN];
  int                          first_cut   [MAX_LEN];
  int                          held_count = 0;

  // handshake bookkeeping and pacing
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  bit   src_burst = 1'b0;
  bit   snk_burst = 1'b0;
  int   src_gap = 0;
  int   snk_wait = 0;
  int   hold_cycles = 0;

  // run statistics
  int beats_owed = 0;
  int items_queued = 0;
  int beats_taken = 0;
  int beats_dropped = 0;
  int lists_closed = 0;
  int pieces_checked = 0;
  int longest_n = 0;
  int mismatches = 0;

  rod_cutting_optimizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // price beat into the shadow list; on the closing beat solve and plan the cuts
  task automatic collect_price(input logic [rco_pkg::PRICE_W-1:0] p, input logic is_last);
    int          n;
    int          rem;
    int          piece;
    int unsigned best;
    int unsigned cand;
    piece_t      pc;
    if (held_count < MAX_LEN) begin
      held_prices[held_count] = p;
      held_count++;
    end else begin
      beats_dropped++;
    end
    if (is_last) begin
      n = held_count;
      held_count = 0;
      // bottom-up recurrence, a cut only replaces the best when strictly better
      for (int len = 1; len <= n; len++) begin
        best = held_prices[len-1];
        first_cut[len-1] = len;
        for (int c = 1; c < len; c++) begin
          cand = held_prices[c-1] + best_value[len-c-1];
          if (cand > best) begin
            best = cand;
            first_cut[len-1] = c;
          end
        end
        best_value[len-1] = best;
      end
      // walk the first cuts down to nothing
      rem = n;
      while (rem > 0) begin
        piece = first_cut[rem-1];
        if (piece == 0 || piece > rem) piece = rem;
        rem -= piece;
        pc.len   = piece[rco_pkg::PIECE_LEN_W-1:0];
        pc.price = held_prices[piece-1];
        pc.total = best_value[n-1][rco_pkg::TOTAL_W-1:0];
        pc.fin   = (rem == 0);
        pieces_due = {pieces_due, pc};
      end
      lists_closed++;
      if (n > longest_n) longest_n = n;
    end
  endtask

  task automatic queue_list(input int n, input price_style_t style);
    int          k;
    int          v;
    price_beat_t pb;
    k = $urandom_range(1, 1200);
    for (int pos = 1; pos <= n; pos++) begin
      case (style)
        PR_RANDOM:   v = $urandom_range(0, 65535);
        PR_LINEAR:   v = pos * k + $urandom_range(0, k);
        PR_CONVEX:   v = pos * pos * (k / 40 + 1) + $urandom_range(0, 3 * k);
        PR_MULTIPLE: v = pos * k;
        PR_SPARSE:   v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
        default:     v = (pos <= MAX_LEN) ? 65535 : 0;
      endcase
      pb.price = (v > 65535) ? 16'hFFFF : v[15:0];
      pb.last  = (pos == n);
      price_beats = {price_beats, pb};
      beats_owed++;
      items_queued++;
    end
  endtask

  // sender pause: nothing left to send and every planned piece seen
  task automatic wait_drained();
    while (beats_owed != 0 || pieces_due.size() != 0) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    price_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_acc) src_gap = pick_gap(src_burst);
      if (in_tvalid && !in_acc) begin
        // beat still on offer
      end else if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (price_beats.size() > 0) begin
        beat = price_beats.pop_front();
        in_tdata  <= beat.price;
        in_tlast  <= beat.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready pacing, with the long hold-off on top
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_acc) snk_wait = pick_gap(snk_burst);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
  end

  // monitor: feed the predictor on input beats, check piece beats
  always @(posedge clk) begin
    piece_t got;
    piece_t want;
    in_acc  <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      collect_price(in_tdata[rco_pkg::PRICE_W-1:0], in_tlast);
      beats_taken++;
      beats_owed--;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.len   = out_tdata[rco_pkg::PIECE_LEN_W-1:0];
      got.price = out_tdata[rco_pkg::PIECE_LEN_W +: rco_pkg::PIECE_PRC_W];
      got.total = out_tdata[rco_pkg::PIECE_LEN_W + rco_pkg::PIECE_PRC_W +: rco_pkg::TOTAL_W];
      got.fin   = out_tlast;
      if (pieces_due.size() == 0) begin
        $display("%0t: piece beat with nothing expected: len %0d price %0d total %0d last %0b",
                 $time, got.len, got.price, got.total, got.fin);
        mismatches++;
      end else begin
        want = pieces_due.pop_front();
        if (got !== want) begin
          $display("%0t: piece mismatch, expected len %0d price %0d total %0d last %0b",
                   $time, want.len, want.price, want.total, want.fin);
          $display("%0t:                  got      len %0d price %0d total %0d last %0b",
                   $time, got.len, got.price, got.total, got.fin);
          mismatches++;
        end
        pieces_checked++;
      end
    end
  end

  // stimulus sequence
  initial begin
    price_style_t style;
    price_beat_t  db;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed lists
    for (int i = 0; i < N_DIR; i++) begin
      db.price = DIR_PRICES[i];
      db.last  = DIR_LAST[i];
      price_beats = {price_beats, db};
      beats_owed++;
      items_queued++;
    end
    wait_drained();

    // output held off while short lists keep arriving
    src_burst = 1'b1;
    hold_cycles = 500;
    for (int i = 0; i < 6; i++) queue_list($urandom_range(2, 6), PR_RANDOM);
    wait_drained();
    src_burst = 1'b0;

    // full store of top prices, then two beats that must be dropped
    queue_list(MAX_LEN + 2, PR_FLAT_MAX);

    // random lists, mostly short, now and then a long one
    while (items_queued < N_ITEMS) begin
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      style = price_style_t'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) queue_list($urandom_range(40, MAX_LEN), style);
      else queue_list($urandom_range(1, 10), style);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
    repeat (60) @(posedge clk);

    $display("covered %0d price lists from %0d beats (%0d beyond the store), rods up to %0d",
             lists_closed, beats_taken, beats_dropped, longest_n);
    $display("checked %0d piece beats under random gaps and a %0d-cycle output stall",
             pieces_checked, 500);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: rod_cutting_optimizer_core.f
rtl/rco_pkg.sv
rtl/rco_ctrl.sv
rtl/rco_datapath.sv
rtl/rod_cutting_optimizer_core.sv
sim/tb_rod_cutting_optimizer_core.sv
